[rtl/tcrs_pkg.sv]
// types and constants shared by the coverage run segmenter
`timescale 1ns / 1ps
`default_nettype none

package tcrs_pkg;

  localparam int unsigned NIB_W     = 4;
  localparam int unsigned OUT_POS_W = 32;
  localparam int unsigned SEG_SLOTS = 2;
  localparam logic [NIB_W-1:0] TYPED_DEPTH_RST = 4'd1;

  // one base of the signal stream
  typedef struct packed {
    logic [NIB_W-1:0] depth;
    logic [NIB_W-1:0] type_code;
    logic             contig_last;
  } tcrs_req_t;

  // one emitted segment
  typedef struct packed {
    logic [OUT_POS_W-1:0] seg_start;
    logic [OUT_POS_W-1:0] seg_end;
    logic [NIB_W-1:0]     seg_depth;
    logic [NIB_W-1:0]     seg_type;
    logic                 type_shown;
    logic                 contig_end;
    logic                 last_of_item;
  } tcrs_seg_t;

  // segments written to the queue in one cycle, in order
  typedef struct packed {
    logic [1:0] num;
    tcrs_seg_t  seg0;
    tcrs_seg_t  seg1;
  } tcrs_push_t;

endpackage

`default_nettype wire

[rtl/tcrs_seg_queue.sv]
// two-slot queue: takes up to two segments, gives one per cycle when ready
`timescale 1ns / 1ps
`default_nettype none

module tcrs_seg_queue (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  tcrs_pkg::tcrs_push_t  push_i,
  output logic [1:0]            free_o,
  output logic                  out_valid_o,
  input  wire                   out_ready_i,
  output tcrs_pkg::tcrs_seg_t   out_seg_o
);

  tcrs_pkg::tcrs_seg_t ent_q [2];
  tcrs_pkg::tcrs_seg_t ent_d [2];
  logic [1:0] cnt_q, cnt_d;
  logic [1:0] base;
  logic       pop;

  assign pop         = (cnt_q != 2'd0) && out_ready_i;
  assign base        = cnt_q - {1'b0, pop};
  assign free_o      = 2'(tcrs_pkg::SEG_SLOTS) - base;
  assign out_valid_o = (cnt_q != 2'd0);
  assign out_seg_o   = ent_q[0];

  always_comb begin
    ent_d[0] = ent_q[0];
    ent_d[1] = ent_q[1];
    if (pop) begin
      ent_d[0] = ent_q[1];
    end
    // the core only pushes when the segments fit
    if (push_i.num == 2'd2) begin
      ent_d[0] = push_i.seg0;
      ent_d[1] = push_i.seg1;
    end else if (push_i.num == 2'd1) begin
      ent_d[base[0]] = push_i.seg0;
    end
    cnt_d = base + push_i.num;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q[0] <= ent_d[0];
    ent_q[1] <= ent_d[1];
  end

endmodule

`default_nettype wire

[rtl/tcrs_core.sv]
// request register, run state and segment formation
`timescale 1ns / 1ps
`default_nettype none

module tcrs_core #(
  parameter int unsigned POS_BITS = 32
) (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   in_valid_i,
  output logic                  in_ready_o,
  input  tcrs_pkg::tcrs_req_t   in_req_i,
  input  wire [3:0]             typed_depth_i,
  input  wire [1:0]             free_i,
  output tcrs_pkg::tcrs_push_t  push_o
);

  localparam int unsigned WIDE_W = (POS_BITS > tcrs_pkg::OUT_POS_W) ? POS_BITS
                                                                     : tcrs_pkg::OUT_POS_W;
  localparam logic [POS_BITS-1:0] POS_MAX = {POS_BITS{1'b1}};

  function automatic logic [tcrs_pkg::OUT_POS_W-1:0] out_pos(input logic [POS_BITS-1:0] p);
    logic [WIDE_W-1:0] pw;
    pw = WIDE_W'(p);
    if (pw > WIDE_W'({tcrs_pkg::OUT_POS_W{1'b1}})) begin
      return {tcrs_pkg::OUT_POS_W{1'b1}};
    end
    return pw[tcrs_pkg::OUT_POS_W-1:0];
  endfunction

  logic                req_valid_q;
  tcrs_pkg::tcrs_req_t req_q;

  logic [POS_BITS-1:0] start_q, start_d;
  logic [POS_BITS-1:0] pos_q, pos_d;
  logic [3:0]          depth_q, depth_d;
  logic [3:0]          type_q, type_d;
  logic                open_q, open_d;

  logic [POS_BITS-1:0] cur;
  logic [POS_BITS-1:0] new_start;
  logic [3:0]          new_depth, new_type;
  logic                split;
  logic [1:0]          need;
  logic                fire;

  assign cur   = (pos_q == POS_MAX) ? pos_q : pos_q + 1'b1;
  assign split = open_q && ((req_q.depth != depth_q) ||
                 ((depth_q == typed_depth_i) && (req_q.type_code != type_q)));
  assign new_start = (split || !open_q) ? cur : start_q;
  assign new_depth = (split || !open_q) ? req_q.depth : depth_q;
  assign new_type  = (split || !open_q) ? req_q.type_code : type_q;
  assign need  = {1'b0, split} + {1'b0, req_q.contig_last};
  assign fire  = req_valid_q && (need <= free_i);
  assign in_ready_o = !req_valid_q || fire;

  always_comb begin
    tcrs_pkg::tcrs_seg_t seg_a;
    tcrs_pkg::tcrs_seg_t seg_b;

    // closed run: ends on the base before this one
    seg_a.seg_start    = out_pos(start_q);
    seg_a.seg_end      = out_pos(cur - 1'b1);
    seg_a.seg_depth    = depth_q;
    seg_a.seg_type     = type_q;
    seg_a.type_shown   = (depth_q == typed_depth_i);
    seg_a.contig_end   = 1'b0;
    seg_a.last_of_item = !req_q.contig_last;

    // final run of the contig, ends on this base
    seg_b.seg_start    = out_pos(new_start);
    seg_b.seg_end      = out_pos(cur);
    seg_b.seg_depth    = new_depth;
    seg_b.seg_type     = new_type;
    seg_b.type_shown   = (new_depth == typed_depth_i);
    seg_b.contig_end   = 1'b1;
    seg_b.last_of_item = 1'b1;

    push_o.num  = fire ? need : 2'd0;
    push_o.seg0 = split ? seg_a : seg_b;
    push_o.seg1 = seg_b;

    start_d = start_q;
    pos_d   = pos_q;
    depth_d = depth_q;
    type_d  = type_q;
    open_d  = open_q;
    if (fire) begin
      if (req_q.contig_last) begin
        start_d = '0;
        pos_d   = '0;
        depth_d = '0;
        type_d  = '0;
        open_d  = 1'b0;
      end else begin
        start_d = new_start;
        pos_d   = cur;
        depth_d = new_depth;
        type_d  = new_type;
        open_d  = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
      start_q     <= '0;
      pos_q       <= '0;
      depth_q     <= '0;
      type_q      <= '0;
      open_q      <= 1'b0;
    end else begin
      req_valid_q <= in_valid_i || (req_valid_q && !fire);
      start_q     <= start_d;
      pos_q       <= pos_d;
      depth_q     <= depth_d;
      type_q      <= type_d;
      open_q      <= open_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      req_q <= in_req_i;
    end
  end

endmodule

`default_nettype wire

[rtl/typed_coverage_run_segmenter.sv]
// top level of the typed coverage run segmenter
// a request is registered at accept; its segments are written into the output
//   queue registers when the queue has room, and are offered from there
// throughput: one request per cycle while the queue has room; a two-segment
//   request (closes a run, ends the contig) drains one segment per ready cycle
// reset: no run open, position zero, output queue empty, typed_depth back to 1
`timescale 1ns / 1ps
`default_nettype none

module typed_coverage_run_segmenter #(
  parameter int unsigned POS_BITS = 32
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  // base stream
  input  wire                  in_valid_i,
  output logic                 in_ready_o,
  input  tcrs_pkg::tcrs_req_t  in_req_i,
  // segment stream
  output logic                 out_valid_o,
  input  wire                  out_ready_i,
  output tcrs_pkg::tcrs_seg_t  out_seg_o,
  // typed depth register
  input  wire                  cfg_we_i,
  input  wire [3:0]            cfg_wdata_i
);

  logic [3:0]           typed_depth_q;
  logic [1:0]           free;
  tcrs_pkg::tcrs_push_t push;

  // depth at which a change of evidence type also splits a run
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      typed_depth_q <= tcrs_pkg::TYPED_DEPTH_RST;
    end else if (cfg_we_i) begin
      typed_depth_q <= cfg_wdata_i;
    end
  end

  // run tracking: compares each base against the open run and forms segments
  tcrs_core #(
    .POS_BITS(POS_BITS)
  ) u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_req_i     (in_req_i),
    .typed_depth_i(typed_depth_q),
    .free_i       (free),
    .push_o       (push)
  );

  // output side: holds up to two segments so a two-segment request never stalls
  // the core by itself
  tcrs_seg_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .free_o     (free),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_seg_o  (out_seg_o)
  );

endmodule

`default_nettype wire
